FILE: hw/rtl/gtri_pkg.sv
// Shared constants and arithmetic helpers for the grid trilinear sampler.
// No dependencies; imported by the sampler top level and its checker.
`timescale 1ns / 1ps

package gtri_pkg;

    localparam int NX = 32;
    localparam int NY = 32;
    localparam int NZ = 32;

    localparam int ADDR_W = 15;
    localparam int DEPTH  = 32768;
    localparam int WORD_W = 32;
    localparam int PADDR_W = 5;
    localparam int LATENCY = 6;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd3;
    localparam logic [2:0] REG_SCALE_X  = 3'd4;
    localparam logic [2:0] REG_SCALE_Y  = 3'd5;
    localparam logic [2:0] REG_SCALE_Z  = 3'd6;

    // x-major word index, wrapped to the store depth
    function automatic logic [ADDR_W-1:0] grid_addr(
        input logic [8:0] x,
        input logic [8:0] y,
        input logic [8:0] z
    );
        logic [31:0] t;
        t = (32'(x) * 32'(NY) + 32'(y)) * 32'(NZ) + 32'(z);
        return t[ADDR_W-1:0];
    endfunction

    // (a*(65536-f) + b*f + 32768) >> 16, written as a + (b-a)*f
    function automatic logic [31:0] lerp(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [15:0] f
    );
        logic signed [33:0] diff;
        logic signed [51:0] prod;
        logic signed [51:0] sum;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        prod = 52'(diff * $signed({1'b0, f}));
        sum  = $signed({4'b0000, a, 16'h0000}) + prod + 52'sd32768;
        return sum[47:16];
    endfunction

endpackage

FILE: hw/rtl/gtri_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module gtri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: hw/rtl/grid_trilinear_sampler_top.sv
// Grid trilinear sampler: APB registers, mapping, grid store and blend pipeline.
// Depends on gtri_pkg and gtri_ram.
`timescale 1ns / 1ps

// Takes one command per clock: busy never rises. A load (cmd 0) writes one
// grid word and gives no result; a sample (cmd 1) gives one result beat on
// valid, in command order. The pipeline steps are: subtract, multiply by
// scale, bounds check and store read, then the z, y and x blends. The store
// is held in four copies, each with two read ports, so all eight corners
// are read in the same cycle; loads are written at the read stage so a
// sample always sees every earlier load.
// The receiver cannot stall: take each result in its valid cycle.

module grid_trilinear_sampler_top
    import gtri_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [14:0]        load_index,
    input  logic [31:0]        load_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               valid,
    output logic [31:0]        density,
    output logic               outside
);

    localparam logic [47:0] LIM_X = 48'(NX - 1) << 16;
    localparam logic [47:0] LIM_Y = 48'(NY - 1) << 16;
    localparam logic [47:0] LIM_Z = 48'(NZ - 1) << 16;

    // configuration
    logic        enable_reg;
    logic [31:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic [31:0] scale_x_reg, scale_y_reg, scale_z_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            scale_x_reg  <= 32'h0001_0000;
            scale_y_reg  <= 32'h0001_0000;
            scale_z_reg  <= 32'h0001_0000;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_ENABLE:   enable_reg   <= pwdata[0];
                REG_ORIGIN_X: origin_x_reg <= pwdata;
                REG_ORIGIN_Y: origin_y_reg <= pwdata;
                REG_ORIGIN_Z: origin_z_reg <= pwdata;
                REG_SCALE_X:  scale_x_reg  <= pwdata;
                REG_SCALE_Y:  scale_y_reg  <= pwdata;
                REG_SCALE_Z:  scale_z_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ENABLE:   prdata = {31'h0, enable_reg};
            REG_ORIGIN_X: prdata = origin_x_reg;
            REG_ORIGIN_Y: prdata = origin_y_reg;
            REG_ORIGIN_Z: prdata = origin_z_reg;
            REG_SCALE_X:  prdata = scale_x_reg;
            REG_SCALE_Y:  prdata = scale_y_reg;
            REG_SCALE_Z:  prdata = scale_z_reg;
            default:      prdata = '0;
        endcase
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // stage 1: offsets from origin
    logic               v1_reg, c1_reg;
    logic [14:0]        li1_reg;
    logic [31:0]        lv1_reg;
    logic signed [32:0] dx1_reg, dy1_reg, dz1_reg;

    // stage 2: grid coordinates
    logic        v2_reg, c2_reg;
    logic [14:0] li2_reg;
    logic [31:0] lv2_reg;
    logic [47:0] gx2_reg, gy2_reg, gz2_reg;
    logic        nx2_reg, ny2_reg, nz2_reg;

    // stage 3: corner words
    logic        v3_reg, en3_reg, out3_reg, last3_reg;
    logic [15:0] fx3_reg, fy3_reg, fz3_reg;

    // stage 4: z blends
    logic        v4_reg, en4_reg, out4_reg, last4_reg;
    logic [15:0] fx4_reg, fy4_reg;
    logic [31:0] zl4_reg [4];
    logic [31:0] low4_reg;

    // stage 5: y blends
    logic        v5_reg, en5_reg, out5_reg, last5_reg;
    logic [15:0] fx5_reg;
    logic [31:0] w5_reg [2];
    logic [31:0] low5_reg;

    logic        valid_reg;
    logic [31:0] density_reg, density_next;
    logic        outside_reg, outside_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= accept;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg && c2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            valid_reg <= v5_reg;
        end
    end

    // stage 2 combinational: bounds, cells and corner addresses
    logic        ox, oy, oz, last2;
    logic [8:0]  x0, y0, z0, x1, y1, z1;
    logic [ADDR_W-1:0] ra_a [4];
    logic [ADDR_W-1:0] ra_b [4];
    logic [31:0] q_a [4];
    logic [31:0] q_b [4];

    assign ox = nx2_reg || (gx2_reg > LIM_X);
    assign oy = ny2_reg || (gy2_reg > LIM_Y);
    assign oz = nz2_reg || (gz2_reg > LIM_Z);
    assign x0 = {1'b0, gx2_reg[23:16]};
    assign y0 = {1'b0, gy2_reg[23:16]};
    assign z0 = {1'b0, gz2_reg[23:16]};
    assign x1 = x0 + 9'd1;
    assign y1 = y0 + 9'd1;
    assign z1 = z0 + 9'd1;
    assign last2 = (x0 == 9'(NX - 1)) || (y0 == 9'(NY - 1)) || (z0 == 9'(NZ - 1));

    // copy j serves corner (dx, dy) = (j[1], j[0]); port a low z, port b high z
    for (genvar j = 0; j < 4; j++)
    begin : g_copy
        assign ra_a[j] = grid_addr(j[1] ? x1 : x0, j[0] ? y1 : y0, z0);
        assign ra_b[j] = grid_addr(j[1] ? x1 : x0, j[0] ? y1 : y0, z1);

        gtri_ram #(
            .WIDTH(WORD_W),
            .DEPTH(DEPTH)
        ) u_ram (
            .clk     (clk),
            .we      (v2_reg && !c2_reg),
            .waddr   (li2_reg),
            .wdata   (lv2_reg),
            .raddr_a (ra_a[j]),
            .raddr_b (ra_b[j]),
            .rdata_a (q_a[j]),
            .rdata_b (q_b[j])
        );
    end

    always_comb
    begin
        if (!en5_reg)
        begin
            density_next = '0;
            outside_next = 1'b0;
        end
        else if (out5_reg)
        begin
            density_next = '0;
            outside_next = 1'b1;
        end
        else if (last5_reg)
        begin
            density_next = low5_reg;
            outside_next = 1'b0;
        end
        else
        begin
            density_next = lerp(w5_reg[0], w5_reg[1], fx5_reg);
            outside_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1
        c1_reg  <= cmd;
        li1_reg <= load_index;
        lv1_reg <= load_value;
        dx1_reg <= 33'(pos_x) - 33'($signed(origin_x_reg));
        dy1_reg <= 33'(pos_y) - 33'($signed(origin_y_reg));
        dz1_reg <= 33'(pos_z) - 33'($signed(origin_z_reg));
        // stage 2
        c2_reg  <= c1_reg;
        li2_reg <= li1_reg;
        lv2_reg <= lv1_reg;
        nx2_reg <= dx1_reg[32];
        ny2_reg <= dy1_reg[32];
        nz2_reg <= dz1_reg[32];
        gx2_reg <= 48'((64'(dx1_reg[31:0]) * 64'(scale_x_reg)) >> 16);
        gy2_reg <= 48'((64'(dy1_reg[31:0]) * 64'(scale_y_reg)) >> 16);
        gz2_reg <= 48'((64'(dz1_reg[31:0]) * 64'(scale_z_reg)) >> 16);
        // stage 3
        en3_reg   <= enable_reg;
        out3_reg  <= ox || oy || oz;
        last3_reg <= last2;
        fx3_reg   <= gx2_reg[15:0];
        fy3_reg   <= gy2_reg[15:0];
        fz3_reg   <= gz2_reg[15:0];
        // stage 4
        en4_reg   <= en3_reg;
        out4_reg  <= out3_reg;
        last4_reg <= last3_reg;
        fx4_reg   <= fx3_reg;
        fy4_reg   <= fy3_reg;
        low4_reg  <= q_a[0];
        for (int k = 0; k < 4; k++)
        begin
            zl4_reg[k] <= lerp(q_a[k], q_b[k], fz3_reg);
        end
        // stage 5
        en5_reg   <= en4_reg;
        out5_reg  <= out4_reg;
        last5_reg <= last4_reg;
        fx5_reg   <= fx4_reg;
        low5_reg  <= low4_reg;
        w5_reg[0] <= lerp(zl4_reg[0], zl4_reg[1], fy4_reg);
        w5_reg[1] <= lerp(zl4_reg[2], zl4_reg[3], fy4_reg);
        // result
        density_reg <= density_next;
        outside_reg <= outside_next;
    end

    assign valid   = valid_reg;
    assign density = density_reg;
    assign outside = outside_reg;

endmodule

FILE: hw/rtl/gtri_chk.sv
// Port-level checker for the grid trilinear sampler, with its bind.
// Depends on gtri_pkg and grid_trilinear_sampler_top.
`timescale 1ns / 1ps

module gtri_chk
    import gtri_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        cmd,
    input logic        valid,
    input logic [31:0] density,
    input logic        outside
);

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_beat_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(start && !busy && cmd, LATENCY))
        else $error("result beat without a sample");

    a_sample_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd) |-> ##LATENCY valid)
        else $error("sample lost");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && outside) |-> (density == 32'h0))
        else $error("outside beat with nonzero density");

endmodule

bind grid_trilinear_sampler_top gtri_chk u_gtri_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .valid   (valid),
    .density (density),
    .outside (outside)
);
